@@ src/pjs_pkg.sv @@
// Shared types and constants for the priority job sorter.
package pjs_pkg;

	localparam int PRIO_W       = 8;
	localparam int IDENT_W      = 22;
	localparam int MAX_JOBS_DEF = 16;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [IDENT_W-1:0] ident;
	} job_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

@@ src/pjs_cell.sv @@
// One sorting cell: holds a job, takes a new or left job on insert, shifts left on emit.
module pjs_cell (
	input  logic              clk,
	input  pjs_pkg::cell_ctrl_t ctrl,
	input  logic              occ,
	input  pjs_pkg::job_t     new_job,
	input  pjs_pkg::job_t     left_job,
	input  logic              left_lt,
	input  pjs_pkg::job_t     right_job,
	output pjs_pkg::job_t     job_q,
	output logic              lt
);

	assign lt = !occ || (new_job.prio < job_q.prio);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			job_q <= right_job;
		end else if (ctrl.insert) begin
			if (left_lt) begin
				job_q <= left_job;
			end else if (lt) begin
				job_q <= new_job;
			end
		end
	end

endmodule

@@ src/priority_job_sorter_core.sv @@
// Top level of the priority job sorter: a row of sorting cells and its control.
// Jobs load one per cycle while busy is low; each job is placed in its sorted slot
// of the cell row in the cycle it is taken. The job that carries batch_end raises
// busy in the next cycle; then the row shifts one job per cycle toward the output,
// so a batch of n stored jobs gives its n results on consecutive cycles, each valid
// for one cycle with out_valid and no way to stall. busy falls in the cycle that
// shows the last result, and a new batch may start right then. Equal priorities keep
// their arrival order. Loading and emitting go one job at a time, set by the single
// insert port and the single output cell of the row.
module priority_job_sorter_core #(
	parameter int MAX_JOBS = pjs_pkg::MAX_JOBS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [pjs_pkg::PRIO_W-1:0]  job_priority,
	input  logic [pjs_pkg::IDENT_W-1:0] job_ident,
	input  logic                       batch_end,
	output logic                       out_valid,
	output logic [pjs_pkg::PRIO_W-1:0]  out_priority,
	output logic [pjs_pkg::IDENT_W-1:0] out_ident,
	output logic                       out_last,
	output logic                       overflow
);

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	logic [CNT_W-1:0]    count_q;
	logic                dropped_q;
	logic                emitting_q;
	logic                accept;
	logic                room;
	logic                final_emit;
	pjs_pkg::cell_ctrl_t ctrl;
	pjs_pkg::job_t       new_job;
	pjs_pkg::job_t       cell_job [MAX_JOBS];
	logic                cell_lt  [MAX_JOBS];

	assign busy       = emitting_q;
	assign accept     = start && !busy;
	assign room       = count_q < CNT_W'(MAX_JOBS);
	assign final_emit = count_q == CNT_W'(1);
	assign new_job    = '{prio: job_priority, ident: job_ident};
	assign ctrl       = '{insert: accept && room, shift: emitting_q};

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		pjs_pkg::job_t left_job;
		pjs_pkg::job_t right_job;
		logic          left_lt;

		if (i == 0) begin : g_head
			assign left_job = new_job;
			assign left_lt  = 1'b0;
		end else begin : g_mid
			assign left_job = cell_job[i-1];
			assign left_lt  = cell_lt[i-1];
		end

		if (i == MAX_JOBS - 1) begin : g_tail
			assign right_job = cell_job[i];
		end else begin : g_body
			assign right_job = cell_job[i+1];
		end

		pjs_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (count_q > CNT_W'(i)),
			.new_job   (new_job),
			.left_job  (left_job),
			.left_lt   (left_lt),
			.right_job (right_job),
			.job_q     (cell_job[i]),
			.lt        (cell_lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			emitting_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			out_valid <= emitting_q;
			if (accept) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				if (batch_end) begin
					emitting_q <= 1'b1;
				end
			end
			if (emitting_q) begin
				count_q <= count_q - CNT_W'(1);
				if (final_emit) begin
					emitting_q <= 1'b0;
					dropped_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emitting_q) begin
			out_priority <= cell_job[0].prio;
			out_ident    <= cell_job[0].ident;
			out_last     <= final_emit;
			overflow     <= final_emit && dropped_q;
		end
	end

endmodule

@@ src/pjs_checker.sv @@
// Port-level checks for the priority job sorter, bound to the top level.
module pjs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic batch_end,
	input logic out_valid,
	input logic out_last,
	input logic overflow
);

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> !busy)
		else $error("busy still high on last result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> busy)
		else $error("busy low before last result");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> out_last)
		else $error("overflow off the last result");

	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> out_valid && out_last)
		else $error("busy fell without last result");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && batch_end |=> busy)
		else $error("batch end did not raise busy");

endmodule

bind priority_job_sorter_core pjs_checker u_pjs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.batch_end (batch_end),
	.out_valid (out_valid),
	.out_last  (out_last),
	.overflow  (overflow)
);

@@ tb/sv/sorted_job_monitor.sv @@
// Checker for the priority job sorter: predicts sorted batches and compares each result.
`timescale 1ns / 1ps

module sorted_job_monitor #(
	parameter int DEPTH = pjs_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [pjs_pkg::PRIO_W-1:0]  job_priority,
	input  logic [pjs_pkg::IDENT_W-1:0] job_ident,
	input  logic                        batch_end,
	input  logic                        out_valid,
	input  logic [pjs_pkg::PRIO_W-1:0]  out_priority,
	input  logic [pjs_pkg::IDENT_W-1:0] out_ident,
	input  logic                        out_last,
	input  logic                        overflow,
	output int                          fail_count,
	output int                          due_count
);

	typedef struct packed {
		logic [pjs_pkg::PRIO_W-1:0]  prio;
		logic [pjs_pkg::IDENT_W-1:0] ident;
		logic                        last;
		logic                        ovf;
	} sorted_job_t;

	pjs_pkg::job_t held [DEPTH];
	int            held_count;
	logic          drop_seen;
	sorted_job_t   sorted_due [$];

	task automatic release_batch();
		pjs_pkg::job_t ordered [DEPTH];
		pjs_pkg::job_t pick;
		sorted_job_t   res;
		int            k;
		for (int i = 0; i < held_count; i++) begin
			pick = held[i];
			k = i;
			while (k > 0 && ordered[k-1].prio > pick.prio) begin
				ordered[k] = ordered[k-1];
				k--;
			end
			ordered[k] = pick;
		end
		for (int i = 0; i < held_count; i++) begin
			res.prio  = ordered[i].prio;
			res.ident = ordered[i].ident;
			res.last  = (i == held_count - 1);
			res.ovf   = res.last & drop_seen;
			sorted_due.push_back(res);
		end
		held_count = 0;
		drop_seen  = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			drop_seen  = 1'b0;
			sorted_due.delete();
			fail_count = 0;
			due_count  = 0;
		end else begin
			if (out_valid) begin
				if (sorted_due.size() == 0) begin
					$display("%0t unexpected result: expected none, actual prio %0d ident %h",
						$time, out_priority, out_ident);
					fail_count++;
				end else begin
					sorted_job_t want;
					want = sorted_due.pop_front();
					if (out_priority !== want.prio) begin
						$display("%0t out_priority: expected %0d, actual %0d",
							$time, want.prio, out_priority);
						fail_count++;
					end
					if (out_ident !== want.ident) begin
						$display("%0t out_ident: expected %h, actual %h",
							$time, want.ident, out_ident);
						fail_count++;
					end
					if (out_last !== want.last) begin
						$display("%0t out_last: expected %b, actual %b",
							$time, want.last, out_last);
						fail_count++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t overflow: expected %b, actual %b",
							$time, want.ovf, overflow);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				if (held_count < DEPTH) begin
					held[held_count].prio  = job_priority;
					held[held_count].ident = job_ident;
					held_count++;
				end else begin
					drop_seen = 1'b1;
				end
				if (batch_end)
					release_batch();
			end
			due_count = sorted_due.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the priority job sorter: clock, reset, job stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH        = pjs_pkg::MAX_JOBS_DEF;
	localparam int RANDOM_ITEMS = 300;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [pjs_pkg::PRIO_W-1:0]  job_priority;
	logic [pjs_pkg::IDENT_W-1:0] job_ident;
	logic                        batch_end;
	logic                        out_valid;
	logic [pjs_pkg::PRIO_W-1:0]  out_priority;
	logic [pjs_pkg::IDENT_W-1:0] out_ident;
	logic                        out_last;
	logic                        overflow;
	int                          fail_count;
	int                          due_count;
	int                          sent;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	priority_job_sorter_core #(
		.MAX_JOBS(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.job_priority(job_priority),
		.job_ident   (job_ident),
		.batch_end   (batch_end),
		.out_valid   (out_valid),
		.out_priority(out_priority),
		.out_ident   (out_ident),
		.out_last    (out_last),
		.overflow    (overflow)
	);

	sorted_job_monitor #(
		.DEPTH(DEPTH)
	) monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.job_priority(job_priority),
		.job_ident   (job_ident),
		.batch_end   (batch_end),
		.out_valid   (out_valid),
		.out_priority(out_priority),
		.out_ident   (out_ident),
		.out_last    (out_last),
		.overflow    (overflow),
		.fail_count  (fail_count),
		.due_count   (due_count)
	);

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 30);
		if (n > 0) begin
			start        <= 1'b0;
			job_priority <= pjs_pkg::PRIO_W'($urandom);
			job_ident    <= pjs_pkg::IDENT_W'($urandom);
			batch_end    <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_job(input logic [pjs_pkg::PRIO_W-1:0] prio,
		input logic [pjs_pkg::IDENT_W-1:0] ident, input logic fin);
		idle_gap();
		start        <= 1'b1;
		job_priority <= prio;
		job_ident    <= ident;
		batch_end    <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	function automatic logic [pjs_pkg::PRIO_W-1:0] pick_prio(input int mode);
		logic [pjs_pkg::PRIO_W-1:0] p;
		case (mode)
			0: p = pjs_pkg::PRIO_W'($urandom_range(0, 3));
			1: begin
				case ($urandom_range(0, 3))
					0: p = 8'd0;
					1: p = 8'd1;
					2: p = 8'd254;
					default: p = 8'd255;
				endcase
			end
			default: p = pjs_pkg::PRIO_W'($urandom_range(0, 255));
		endcase
		return p;
	endfunction

	initial begin
		int base;
		int jobs;
		int mode;
		int r;
		int guard;
		logic [pjs_pkg::IDENT_W-1:0] id;
		sent         = 0;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		job_priority <= '0;
		job_ident    <= '0;
		batch_end    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_job(8'd255, 22'h3FFFFF, 1'b1);
		send_job(8'd0, 22'h000000, 1'b1);
		send_job(8'd7, 22'h000001, 1'b0);
		send_job(8'd3, 22'h2AAAAA, 1'b0);
		send_job(8'd7, 22'h155555, 1'b0);
		send_job(8'd3, 22'h000004, 1'b1);
		for (int i = 0; i < DEPTH + 1; i++)
			send_job(8'(200 - 10 * i), 22'(i + 16), i == DEPTH);

		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				jobs = $urandom_range(DEPTH + 1, DEPTH + 4);
			else if (r < 20)
				jobs = DEPTH;
			else
				jobs = $urandom_range(1, 12);
			mode = $urandom_range(0, 3);
			for (int i = 0; i < jobs; i++) begin
				id = pjs_pkg::IDENT_W'($urandom);
				send_job(pick_prio(mode), id, i == jobs - 1);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (due_count != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
